@@ rtl/htbd_pkg.sv @@
// ----------------------------------------------------------------------------
// htbd_pkg: shared types and constants for the Huffman tree bit decoder
// Action and status codes, field widths, and the command and status structs
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package htbd_pkg;

  localparam int NODES_DEF    = 1024;  // default node store depth
  localparam int SYMBOLS      = 288;   // symbols >= this are rejected by add
  localparam int MAX_CODE_LEN = 15;    // longer codes are rejected by add

  localparam int SYM_W  = 9;
  localparam int CODE_W = 15;
  localparam int LEN_W  = 4;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_DECODE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SYM  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  // Controller -> datapath
  typedef struct packed {
    logic    accept;       // load the input beat
    logic    clear;        // reset tree to a bare root
    logic    walk_add;     // link lookup follows the add path
    logic    add_step;     // follow an existing link
    logic    add_alloc;    // allocate a node and link it
    logic    add_zero;     // clear both links of the new node
    logic    add_mark;     // mark the final node with the symbol
    logic    dec_check;    // evaluate the decode link
    logic    dec_settle;   // move cursor after the symbol lookup
    logic    res_load;     // a result is ready this cycle
    status_t res_status;
    logic    res_sym_sel;  // take the symbol from the node store
    logic    pend_emit;    // move the held result to the output
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    action_t action;
    logic    add_ok;
    logic    link_zero;
    logic    store_full;
    logic    last_level;
    logic    leaf;
    logic    out_free;
  } sts_t;

endpackage

@@ rtl/htbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// htbd_ctrl: sequencing state machine
// Accepts one beat at a time, walks the add or decode sequence and hands the
// result to the output stage, holding it when the output is still occupied.
// ----------------------------------------------------------------------------
module htbd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  htbd_pkg::sts_t sts,
  output htbd_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ADD_CHK  = 7'b0000010,
    S_ADD_ZERO = 7'b0000100,
    S_ADD_MARK = 7'b0001000,
    S_DEC_CHK  = 7'b0010000,
    S_DEC_SYM  = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.res_status = htbd_pkg::ST_OK;
    state_nxt      = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (sts.action)
            htbd_pkg::ACT_CLEAR: begin
              cmd.clear    = 1'b1;
              cmd.res_load = 1'b1;
            end
            htbd_pkg::ACT_ADD: begin
              if (sts.add_ok) begin
                state_nxt = S_ADD_CHK;
              end else begin
                cmd.res_load = 1'b1;
              end
            end
            htbd_pkg::ACT_DECODE: begin
              state_nxt = S_DEC_CHK;
            end
            default: begin
              cmd.res_load = 1'b1;
            end
          endcase
        end
      end
      S_ADD_CHK: begin
        cmd.walk_add = 1'b1;
        if (sts.link_zero) begin
          if (sts.store_full) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = htbd_pkg::ST_FULL;
          end else begin
            cmd.add_alloc = 1'b1;
            state_nxt     = S_ADD_ZERO;
          end
        end else begin
          cmd.add_step = 1'b1;
          if (sts.last_level) begin
            state_nxt = S_ADD_MARK;
          end
        end
      end
      S_ADD_ZERO: begin
        cmd.walk_add = 1'b1;
        cmd.add_zero = 1'b1;
        state_nxt    = sts.last_level ? S_ADD_MARK : S_ADD_CHK;
      end
      S_ADD_MARK: begin
        cmd.add_mark = 1'b1;
        cmd.res_load = 1'b1;
      end
      S_DEC_CHK: begin
        cmd.dec_check = 1'b1;
        if (sts.link_zero) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = htbd_pkg::ST_MISS;
        end else begin
          state_nxt = S_DEC_SYM;
        end
      end
      S_DEC_SYM: begin
        cmd.dec_settle  = 1'b1;
        cmd.res_load    = 1'b1;
        cmd.res_status  = sts.leaf ? htbd_pkg::ST_SYM : htbd_pkg::ST_OK;
        cmd.res_sym_sel = sts.leaf;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.pend_emit = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // Hold the result when the output register cannot take it yet
    if (cmd.res_load) begin
      state_nxt = sts.out_free ? S_IDLE : S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/htbd_dpath.sv @@
// ----------------------------------------------------------------------------
// htbd_dpath: node store, walk registers and output stage
// Holds the link and symbol memories, the root links in flops, the free
// pointer, the decode cursor and the registered result.
// ----------------------------------------------------------------------------
module htbd_dpath #(
  parameter int NODES = htbd_pkg::NODES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    in_action,
  input  logic [htbd_pkg::SYM_W-1:0]    in_symbol,
  input  logic [htbd_pkg::CODE_W-1:0]   in_code_bits,
  input  logic [htbd_pkg::LEN_W-1:0]    in_code_length,
  input  logic                          in_bit_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [htbd_pkg::SYM_W-1:0]    out_decoded_symbol,
  input  htbd_pkg::cmd_t                cmd,
  output htbd_pkg::sts_t                sts
);

  localparam int NW = $clog2(NODES);
  localparam int FW = NW + 1;
  localparam int SW = htbd_pkg::SYM_W + 1;  // leaf flag on top

  logic [NW-1:0] left_mem  [NODES];
  logic [NW-1:0] right_mem [NODES];
  logic [SW-1:0] sym_mem   [NODES];

  logic [NW-1:0] left_q_r, right_q_r;
  logic [SW-1:0] sym_q_r;

  logic [NW-1:0] root_left_r, root_right_r;
  logic [FW-1:0] free_r;
  logic [NW-1:0] cursor_r;
  logic [NW-1:0] node_r, node_nxt;
  logic          fresh_r;
  logic [htbd_pkg::LEN_W-1:0]  level_r;
  logic [htbd_pkg::LEN_W-1:0]  lvl_idx;
  logic [htbd_pkg::CODE_W-1:0] code_r;
  logic [htbd_pkg::SYM_W-1:0]  sym_r;
  logic                        bit_r;

  logic          side;
  logic [NW-1:0] pos, link, link_mem, root_side, rd_addr, free_idx;
  logic          last;

  logic          lw_en, rw_en, sw_en;
  logic [NW-1:0] lw_addr, rw_addr, sw_addr, lw_data, rw_data;
  logic [SW-1:0] sw_data;

  htbd_pkg::status_t           res_status, out_status_r, pend_status_r;
  logic [htbd_pkg::SYM_W-1:0]  res_sym, out_sym_r, pend_sym_r;
  logic                        out_valid_r, out_free;

  // --- link lookup -----------------------------------------------------------
  assign lvl_idx   = level_r - 1'b1;
  assign last      = (level_r == htbd_pkg::LEN_W'(1));
  assign side      = cmd.walk_add ? code_r[lvl_idx] : bit_r;
  assign pos       = cmd.walk_add ? node_r : cursor_r;
  assign link_mem  = side ? right_q_r : left_q_r;
  assign root_side = side ? root_right_r : root_left_r;
  assign free_idx  = free_r[NW-1:0];

  always_comb begin
    if (cmd.walk_add && fresh_r) begin
      link = '0;  // children of a node allocated on this path are empty
    end else if (pos == '0) begin
      link = root_side;
    end else begin
      link = link_mem;
    end
  end

  always_comb begin
    node_nxt = node_r;
    if (cmd.accept) begin
      node_nxt = '0;
    end else if (cmd.add_alloc) begin
      node_nxt = free_idx;
    end else if (cmd.add_step || cmd.dec_check) begin
      node_nxt = link;
    end
  end

  assign rd_addr = cmd.walk_add ? node_nxt : cursor_r;

  // --- memory writes ----------------------------------------------------------
  always_comb begin
    lw_en   = 1'b0;
    lw_addr = node_r;
    lw_data = '0;
    rw_en   = 1'b0;
    rw_addr = node_r;
    rw_data = '0;
    sw_en   = 1'b0;
    sw_addr = free_idx;
    sw_data = '0;
    if (cmd.add_alloc) begin
      sw_en = 1'b1;
      if (node_r != '0) begin
        lw_en   = !side;
        lw_data = free_idx;
        rw_en   = side;
        rw_data = free_idx;
      end
    end
    if (cmd.add_zero) begin
      lw_en = 1'b1;
      rw_en = 1'b1;
    end
    if (cmd.add_mark) begin
      sw_en   = 1'b1;
      sw_addr = node_r;
      sw_data = {1'b1, sym_r};
    end
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      left_mem[lw_addr] <= lw_data;
    end
    left_q_r <= left_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rw_en) begin
      right_mem[rw_addr] <= rw_data;
    end
    right_q_r <= right_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (sw_en) begin
      sym_mem[sw_addr] <= sw_data;
    end
    sym_q_r <= sym_mem[link];
  end

  // --- walk and tree state ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_left_r  <= '0;
      root_right_r <= '0;
      free_r       <= FW'(1);
      cursor_r     <= '0;
      fresh_r      <= 1'b0;
    end else begin
      if (cmd.clear) begin
        root_left_r  <= '0;
        root_right_r <= '0;
        free_r       <= FW'(1);
        cursor_r     <= '0;
      end
      if (cmd.accept) begin
        fresh_r <= 1'b0;
      end
      if (cmd.add_alloc) begin
        free_r  <= free_r + 1'b1;
        fresh_r <= 1'b1;
        if (node_r == '0) begin
          if (side) begin
            root_right_r <= free_idx;
          end else begin
            root_left_r <= free_idx;
          end
        end
      end
      if (cmd.dec_check && (link == '0)) begin
        cursor_r <= '0;
      end
      if (cmd.dec_settle) begin
        cursor_r <= sym_q_r[SW-1] ? '0 : node_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    if (cmd.accept) begin
      code_r  <= in_code_bits;
      sym_r   <= in_symbol;
      bit_r   <= in_bit_req;
      level_r <= in_code_length;
    end else if ((cmd.add_step || cmd.add_zero) && !last) begin
      level_r <= level_r - 1'b1;
    end
  end

  // --- result stage -----------------------------------------------------------
  assign out_free   = !out_valid_r || !out_stall;
  assign res_status = cmd.res_status;
  assign res_sym    = cmd.res_sym_sel ? sym_q_r[htbd_pkg::SYM_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      pend_status_r <= res_status;
      pend_sym_r    <= res_sym;
    end
    if (cmd.res_load && out_free) begin
      out_status_r <= res_status;
      out_sym_r    <= res_sym;
    end else if (cmd.pend_emit) begin
      out_status_r <= pend_status_r;
      out_sym_r    <= pend_sym_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.res_load && out_free) || cmd.pend_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_decoded_symbol = out_sym_r;

  // --- status to controller ---------------------------------------------------
  assign sts.action     = htbd_pkg::action_t'(in_action);
  assign sts.add_ok     = (in_code_length != '0)
                          && (32'(in_code_length) <= htbd_pkg::MAX_CODE_LEN)
                          && (32'(in_symbol) < htbd_pkg::SYMBOLS);
  assign sts.link_zero  = (link == '0);
  assign sts.store_full = (free_r >= FW'(NODES));
  assign sts.last_level = last;
  assign sts.leaf       = sym_q_r[SW-1];
  assign sts.out_free   = out_free;

  // --- assertions -------------------------------------------------------------
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r >= FW'(1)) && (free_r <= FW'(NODES)))
    else $error("free pointer out of range");

  a_cursor_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cursor_r} < free_r)
    else $error("cursor points at an unallocated node");

  a_fresh_node: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r |-> ({1'b0, node_r} == (free_r - 1'b1)))
    else $error("fresh walk node is not the last allocated one");

  a_pend_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pend_emit |-> out_free)
    else $error("held result emitted into an occupied output");

endmodule

@@ rtl/huffman_tree_bit_decoder.sv @@
// Sequence: clear, no-op and rejected add beats go straight to the output;
// decode does a link lookup, then a symbol lookup unless the branch is missing;
// add walks level by level, clearing each new node, and stops on a full store.
// Throughput: one beat in flight; the next beat is accepted once the result is
// in the output register, so a stalled output holds off the input.
// Reset: bare root, cursor at the root, output empty; node memories uncleared.
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder: binary code tree builder and bitwise decoder
// Builds a prefix-code tree from (symbol, code, length) beats and decodes one
// stream bit per beat, emitting a symbol on reaching a marked node.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder #(
  // Depth of the node store; node 0 is the root, kept in flops
  parameter int NODES = htbd_pkg::NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel: one action per beat
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [htbd_pkg::SYM_W-1:0]  in_symbol,
  input  logic [htbd_pkg::CODE_W-1:0] in_code_bits,
  input  logic [htbd_pkg::LEN_W-1:0]  in_code_length,
  input  logic                        in_bit_req,
  // Result channel: exactly one beat per input beat
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [htbd_pkg::SYM_W-1:0]  out_decoded_symbol
);

  // Command and status buses between the sequencer and the datapath
  htbd_pkg::cmd_t cmd;
  htbd_pkg::sts_t sts;

  // Sequencer: decodes the action, steps the add walk one tree level at a
  // time (follow, or allocate then clear the new node's links), steps the
  // decode through link lookup and symbol lookup, and holds a finished result
  // while the output register is still occupied.
  htbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: link and symbol memories with registered reads, root links,
  // free pointer, decode cursor, walk registers and the output stage.
  htbd_dpath #(
    .NODES (NODES)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_action          (in_action),
    .in_symbol          (in_symbol),
    .in_code_bits       (in_code_bits),
    .in_code_length     (in_code_length),
    .in_bit_req         (in_bit_req),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_decoded_symbol (out_decoded_symbol),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule
